[hdl/lis_pkg.sv]
// Shared types and constants for the longest increasing subsequence length unit.
// Used by lis_search and by the top level; depends on nothing.
package lis_pkg;

    localparam int MAX_LEN       = 1024;
    localparam int ADDR_W        = $clog2(MAX_LEN);
    localparam int LEN_W         = $clog2(MAX_LEN + 1);
    localparam int POS_W         = 31;
    localparam int OUT_LEN_W     = 11;
    localparam int LEN_FIELD_MAX = 2047;

    // Search request from the top level to the search sequencer.
    typedef struct packed {
        logic             start;
        logic [POS_W-1:0] position;
        logic [LEN_W-1:0] count;
    } lis_req_t;

    // Search completion back to the top level.
    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] slot;
    } lis_rsp_t;

endpackage

[hdl/longest_increasing_subsequence_length_unit.sv]
// Top level of the longest increasing subsequence length unit.
// Depends on lis_pkg, lis_ram and lis_search.
//
// Usage: positions arrive as beats on the s_ channel (s_position, s_last).
// The unit keeps, for each run length, the smallest tail that ends a
// strictly increasing run of that length. Each beat runs a binary search
// over the stored tails and then overwrites one tail or appends a new one.
// The beat that carries s_last produces one result beat on the m_ channel:
// m_lis_length and m_overflow, after which the sequence state is cleared.
// s_ready is high only while no beat is in work, so a new beat is taken
// only once the last one is through. The search loop makes one tail RAM
// read per cycle, each halving the range of stored tails. A last beat then
// passes through ST_EMIT, which loads the result into the output register
// and waits there while that register is still full.
// The result sits in an output register, so new beats are accepted while
// it waits; only a further last beat waits for the receiver to take it.
// Reset clears the length, the overflow flag and all handshake state; the
// tail RAM is not cleared, because only written entries are ever read.
module longest_increasing_subsequence_length_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [lis_pkg::POS_W-1:0]         s_position,
    input  logic                              s_last,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lis_pkg::OUT_LEN_W-1:0]     m_lis_length,
    output logic                              m_overflow
);

    // Control states of the beat sequencer.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [lis_pkg::LEN_W-1:0]     best_reg, best_next;
    logic                          ovf_reg, ovf_next;
    logic                          last_reg;
    logic [lis_pkg::POS_W-1:0]     pos_reg;
    logic                          m_valid_reg, m_valid_next;
    logic [lis_pkg::OUT_LEN_W-1:0] m_len_reg;
    logic                          m_ovf_reg;
    logic                          load_out;
    logic                          s_fire;
    logic [lis_pkg::OUT_LEN_W-1:0] len_sat;

    lis_pkg::lis_req_t             req;
    lis_pkg::lis_rsp_t             rsp;

    logic                          wr_en;
    logic [lis_pkg::ADDR_W-1:0]    wr_addr;
    logic                          rd_en;
    logic [lis_pkg::ADDR_W-1:0]    rd_addr;
    logic [lis_pkg::POS_W-1:0]     rd_data;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    // The search reads the position from pos_reg; it compares only when a tail
    // read has returned, by which time pos_reg already holds the beat's value.
    assign req.start    = s_fire;
    assign req.position = pos_reg;
    assign req.count    = best_reg;

    lis_search u_search (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lis_ram #(
        .WIDTH (lis_pkg::POS_W),
        .DEPTH (lis_pkg::MAX_LEN)
    ) u_tail_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (pos_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The emitted length saturates at the width of the result field.
    always_comb begin
        if (32'(best_reg) > 32'(lis_pkg::LEN_FIELD_MAX)) begin
            len_sat = lis_pkg::OUT_LEN_W'(lis_pkg::LEN_FIELD_MAX);
        end else begin
            len_sat = lis_pkg::OUT_LEN_W'(best_reg);
        end
    end

    // The result register can take a new result when it is empty or its
    // current beat leaves in this cycle.
    assign load_out = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        best_next    = best_reg;
        ovf_next     = ovf_reg;
        wr_en        = 1'b0;
        wr_addr      = rsp.slot[lis_pkg::ADDR_W-1:0];
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (rsp.done) begin
                    // Overwrite an existing tail, append one, or drop the
                    // beat when the table is already full.
                    if (rsp.slot < best_reg) begin
                        wr_en = 1'b1;
                    end else if (32'(best_reg) < lis_pkg::MAX_LEN) begin
                        wr_en     = 1'b1;
                        wr_addr   = best_reg[lis_pkg::ADDR_W-1:0];
                        best_next = best_reg + lis_pkg::LEN_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (load_out) begin
                    m_valid_next = 1'b1;
                    best_next    = '0;
                    ovf_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            best_reg    <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            best_reg    <= best_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pos_reg  <= s_position;
            last_reg <= s_last;
        end
        if (load_out) begin
            m_len_reg <= len_sat;
            m_ovf_reg <= ovf_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_lis_length = m_len_reg;
    assign m_overflow   = m_ovf_reg;

`ifndef SYNTHESIS
    // The number of stored tails never exceeds the table depth.
    a_best_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(best_reg) <= lis_pkg::MAX_LEN)
        else $error("stored tail count exceeds table depth");

    // The search completes only while a beat is in work.
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> (state_reg == ST_BUSY))
        else $error("search completed outside of a beat");

    // The tail RAM is never read and written in the same cycle.
    a_no_rw: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !rd_en)
        else $error("tail RAM read and written together");

    // Emitting a result clears the sequence state for the next sequence.
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> (best_reg == '0) && !ovf_reg && m_valid)
        else $error("sequence state not cleared after result");
`endif

endmodule

[hdl/lis_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; depends on nothing.
module lis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/lis_search.sv]
// Binary search sequencer: finds the first stored tail not less than a position.
// Depends on lis_pkg; drives the read port of the tail RAM.
module lis_search (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lis_pkg::lis_req_t             req,
    output lis_pkg::lis_rsp_t             rsp,
    output logic                          rd_en,
    output logic [lis_pkg::ADDR_W-1:0]    rd_addr,
    input  logic [lis_pkg::POS_W-1:0]     rd_data
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic                      state_reg, state_next;
    logic                      pend_reg, pend_next;
    logic [lis_pkg::LEN_W-1:0] lo_reg, lo_next;
    logic [lis_pkg::LEN_W-1:0] hi_reg, hi_next;
    logic [lis_pkg::LEN_W-1:0] mid_reg, mid_next;
    logic [lis_pkg::LEN_W-1:0] lo_upd, hi_upd;
    logic                      tail_less;

    // The one shared comparator: the tail just read against the position.
    assign tail_less = (rd_data < req.position);

    always_comb begin
        lo_upd = lo_reg;
        hi_upd = hi_reg;
        if (pend_reg) begin
            if (tail_less) begin
                lo_upd = mid_reg + lis_pkg::LEN_W'(1);
            end else begin
                hi_upd = mid_reg;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        pend_next  = 1'b0;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = lo_upd + ((hi_upd - lo_upd) >> 1);
        rd_en      = 1'b0;
        rsp.done   = 1'b0;
        rsp.slot   = lo_upd;
        case (state_reg)
            S_IDLE: begin
                if (req.start) begin
                    state_next = S_RUN;
                    lo_next    = '0;
                    hi_next    = req.count;
                end
            end
            S_RUN: begin
                lo_next = lo_upd;
                hi_next = hi_upd;
                if (hi_upd > lo_upd) begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                end else begin
                    rsp.done   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Whenever a read is issued, the midpoint is below the upper bound, so it fits the address.
    assign rd_addr = mid_next[lis_pkg::ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
    end

endmodule

[verif/tb_top.sv]
// Self-checking testbench for longest_increasing_subsequence_length_unit.
// Needs lis_pkg and the unit's RTL; a scoreboard class predicts each result beat.
`timescale 1ns / 100ps

module tb_top;

    typedef bit [lis_pkg::POS_W-1:0] pos_t;

    typedef struct packed {
        logic [lis_pkg::OUT_LEN_W-1:0] lis_length;
        logic                          overflow;
    } lis_result_t;

    // Flavors of position content used by the random sequences.
    typedef enum int {
        MIX_FULL,
        MIX_NARROW,
        MIX_RISING,
        MIX_EDGES
    } pos_mix_t;

    localparam pos_t        POS_MAX      = '1;
    localparam int unsigned LIMIT_CYCLES = 500000;
    localparam int unsigned RANDOM_ITEMS = 750;
    localparam int unsigned MIN_RANDOM_SEQS = 40;
    localparam int unsigned IDLE_PCT     = 22;
    localparam int unsigned TAIL_CYCLES  = 30;

    // Tracks the tail table of the unit and holds the results still owed.
    class lis_scoreboard;
        pos_t          tails [lis_pkg::MAX_LEN];
        int unsigned   run_len;
        bit            dropped;
        lis_result_t   owed [$];
        int unsigned   errors;

        function new();
            run_len = 0;
            dropped = 1'b0;
            errors  = 0;
        endfunction

        // Applies one accepted input beat: binary search for the first tail that is
        // not below the position, then overwrite it or append a new tail.
        function void note_beat(pos_t pos, bit last);
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            lis_result_t res;
            lo = 0;
            hi = run_len;
            while (hi > lo) begin
                mid = lo + ((hi - lo) >> 1);
                if (tails[mid] < pos) begin
                    lo = mid + 1;
                end else begin
                    hi = mid;
                end
            end
            if (lo < run_len) begin
                tails[lo] = pos;
            end else if (run_len < lis_pkg::MAX_LEN) begin
                tails[run_len] = pos;
                run_len++;
            end else begin
                dropped = 1'b1;
            end
            if (last) begin
                res.lis_length = lis_pkg::OUT_LEN_W'((run_len > lis_pkg::LEN_FIELD_MAX) ?
                                 lis_pkg::LEN_FIELD_MAX : run_len);
                res.overflow   = dropped;
                owed.push_back(res);
                run_len = 0;
                dropped = 1'b0;
            end
        endfunction

        function void check_result(logic [lis_pkg::OUT_LEN_W-1:0] len, logic ovf);
            lis_result_t want;
            if (owed.size() == 0) begin
                $display("%0t: result beat with none owed: lis_length=%0d overflow=%0d",
                         $time, len, ovf);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (want.lis_length !== len) begin
                $display("%0t: lis_length mismatch: expected %0d, actual %0d",
                         $time, want.lis_length, len);
                errors++;
            end
            if (want.overflow !== ovf) begin
                $display("%0t: overflow mismatch: expected %0d, actual %0d",
                         $time, want.overflow, ovf);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return owed.size();
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [lis_pkg::POS_W-1:0]     s_position;
    logic                          s_last;
    logic                          m_valid;
    logic                          m_ready;
    logic [lis_pkg::OUT_LEN_W-1:0] m_lis_length;
    logic                          m_overflow;

    lis_scoreboard sb;
    int unsigned   cycle_count;
    bit            calm;

    longest_increasing_subsequence_length_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_position   (s_position),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_lis_length (m_lis_length),
        .m_overflow   (m_overflow)
    );

    initial aclk = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // The receiver stalls at random, except during the calm stretch.
    always @(posedge aclk) begin
        if (calm) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Both channels are sampled at the edge, so the values seen are the ones
    // the unit saw. Inputs are noted before results; a last beat's own result
    // can never land on the edge that accepts it.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_beat(s_position, s_last);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_lis_length, m_overflow);
            end
        end
    end

    // Presents one beat and returns on the edge that accepts it. Valid is left
    // high so a following beat can go out back to back.
    task automatic send_beat(input pos_t pos, input bit last);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_position <= pos;
        s_last     <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_run(input pos_t vals [$]);
        foreach (vals[i]) begin
            send_beat(vals[i], i == vals.size() - 1);
        end
    endtask

    // Holds the input channel quiet until every owed result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        pos_t        run [$];
        pos_t        prev;
        pos_t        pos;
        pos_mix_t    mix;
        int unsigned items;
        int unsigned seqs;
        int unsigned seq_len;
        int unsigned pick;

        sb          = new();
        cycle_count = 0;
        calm        = 1'b0;
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_position <= '0;
        s_last     <= 1'b0;
        m_ready    <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: single-item sequences at the extremes, repeats that
        // must not count as increasing, strictly rising and falling runs, and a
        // mixed run that exercises overwrites in the middle of the table.
        run = {31'd5};                     send_run(run);
        run = {31'd0};                     send_run(run);
        run = {POS_MAX};                   send_run(run);
        run = {31'd7, 31'd7, 31'd7};       send_run(run);
        run = {31'd10, 31'd20, 31'd30};    send_run(run);
        run = {31'd30, 31'd20, 31'd10};    send_run(run);
        run = {31'd0, POS_MAX};            send_run(run);
        run = {POS_MAX, 31'd0, POS_MAX - 31'd1};
        send_run(run);
        run = {31'd3, 31'd1, 31'd4, 31'd1, 31'd5, 31'd9, 31'd2, 31'd6};
        send_run(run);

        // A table filled exactly to its depth, with no drop.
        for (int i = 0; i < lis_pkg::MAX_LEN; i++) begin
            send_beat(pos_t'(i), i == lis_pkg::MAX_LEN - 1);
        end

        // A full table that still takes overwrites, then drops the last beat,
        // which would have extended it.
        for (int i = 0; i < lis_pkg::MAX_LEN; i++) begin
            send_beat(pos_t'(2 * i + 2), 1'b0);
        end
        send_beat(31'd1, 1'b0);
        send_beat(31'd0, 1'b0);
        send_beat(31'd9000, 1'b1);

        // The flag and length must start clean on the next sequence.
        send_beat(31'd7, 1'b1);

        // Random part: mostly short sequences, a few long ones, with content
        // that ranges from full-width noise to dense duplicates and near-sorted
        // runs that build long tables.
        items = 0;
        seqs  = 0;
        while (items < RANDOM_ITEMS || seqs < MIN_RANDOM_SEQS) begin
            calm = (seqs >= 12 && seqs < 22);
            pick = $urandom_range(99);
            if (pick < 80) begin
                seq_len = $urandom_range(8, 1);
            end else if (pick < 97) begin
                seq_len = $urandom_range(60, 9);
            end else begin
                seq_len = $urandom_range(300, 61);
            end
            mix  = pos_mix_t'($urandom_range(3));
            prev = pos_t'($urandom_range(1000));
            for (int k = 0; k < seq_len; k++) begin
                case (mix)
                    MIX_FULL: begin
                        pos = pos_t'($urandom);
                    end
                    MIX_NARROW: begin
                        pos = pos_t'($urandom_range(15));
                    end
                    MIX_RISING: begin
                        if ($urandom_range(9) == 0) begin
                            pos = pos_t'($urandom_range(prev));
                        end else if (POS_MAX - prev < 40) begin
                            pos = POS_MAX;
                        end else begin
                            pos = prev + pos_t'($urandom_range(40));
                        end
                    end
                    default: begin
                        case ($urandom_range(3))
                            0:       pos = '0;
                            1:       pos = 31'd1;
                            2:       pos = POS_MAX - 31'd1;
                            default: pos = POS_MAX;
                        endcase
                    end
                endcase
                prev = pos;
                send_beat(pos, k == seq_len - 1);
            end
            items += seq_len;
            seqs++;
            // Let the pipeline run dry once in the middle of the random part.
            if (seqs == 26) begin
                wait_drained();
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/lis_pkg.sv
hdl/lis_ram.sv
hdl/lis_search.sv
hdl/longest_increasing_subsequence_length_unit.sv
verif/tb_top.sv
